@@ rtl/arp_cache_and_responder_defines.svh @@
// Assertion macros used by the checker file of the ARP cache.
`ifndef ARP_CACHE_AND_RESPONDER_DEFINES_SVH
`define ARP_CACHE_AND_RESPONDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ARP cache assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ARPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ARP cache assertion failed");

`endif

@@ rtl/arpc_pkg.sv @@
// Shared constants for the ARP cache and request responder.
package arpc_pkg;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = CFG_IDX_W'(1);

  localparam logic        REQ_LEARN  = 1'b0;
  localparam logic        REQ_LOOKUP = 1'b1;

  localparam logic [15:0] OPCODE_REQUEST = 16'h0001;

  localparam logic [31:0] OWN_IP_RST  = 32'h0A00_020F;
  localparam logic [47:0] OWN_MAC_RST = 48'h5254_0012_3456;

endpackage

@@ rtl/arpc_table.sv @@
// Pair storage of the ARP cache: one write port and one registered read port.
module arpc_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [31:0]      wr_ip,
  input  logic [47:0]      wr_mac,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [31:0]      rd_ip_r,
  output logic [47:0]      rd_mac_r
);

  logic [31:0] ip_mem  [DEPTH];
  logic [47:0] mac_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_mem[wr_addr]  <= wr_ip;
      mac_mem[wr_addr] <= wr_mac;
    end
  end

  always_ff @(posedge clk) begin
    rd_ip_r  <= ip_mem[rd_addr];
    rd_mac_r <= mac_mem[rd_addr];
  end

endmodule

@@ rtl/arp_cache_and_responder.sv @@
// Top level of the ARP cache: learns sender pairs, flags replies, scans lookups.
//
//   channel  direction  handshake            contents
//   in_      into block in_valid / in_stall  learn or lookup item
//   out_     from block out_valid / out_stall one result item per input item
//   cfg_     into block cfg_valid / cfg_ready own_ip, own_mac register writes
//
// A learn item passes from acceptance through the result registers to the output register.
// A lookup compares the filled entries (at most TABLE_DEPTH) in ST_SCAN, with the single
// table read port feeding one 32-bit comparator per cycle.
// While an item is being worked on in_stall is high; a result held by out_stall
// waits in the output register while the next item is accepted and worked on.
// rst_n is synchronous; the table contents are not cleared, but the fill count is.
module arp_cache_and_responder import arpc_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [15:0]          in_arp_opcode,
  input  logic [31:0]          in_sender_ip,
  input  logic [47:0]          in_sender_mac,
  input  logic [31:0]          in_target_ip,
  input  logic [31:0]          in_query_ip,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_send_reply,
  output logic [47:0]          out_reply_mac,
  output logic [31:0]          out_reply_ip,
  output logic                 out_lookup_hit,
  output logic [47:0]          out_lookup_mac,
  output logic [4:0]           out_entry_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]          cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      query_r;
  logic [31:0]      own_ip_r;
  logic [47:0]      own_mac_r;

  logic             res_send_r;
  logic [47:0]      res_rmac_r;
  logic [31:0]      res_rip_r;
  logic             res_hit_r;
  logic [47:0]      res_lmac_r;
  logic [CNT_W-1:0] res_count_r;

  logic             out_valid_r;
  logic             out_send_r;
  logic [47:0]      out_rmac_r;
  logic [31:0]      out_rip_r;
  logic             out_hit_r;
  logic [47:0]      out_lmac_r;
  logic [CNT_W-1:0] out_count_r;
  logic [CNT_W+4:0] out_count_ext;

  logic             in_acc;
  logic             out_free;
  logic             wr_en;
  logic             reply_due;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_ip;
  logic [47:0]      rd_mac;
  logic             scan_hit;
  logic             scan_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign wr_en     = in_acc && (in_req_type == REQ_LEARN) && (count_r != DEPTH_C);
  assign reply_due = (in_arp_opcode == OPCODE_REQUEST) && (in_target_ip == own_ip_r);
  assign rd_addr   = (state_r == ST_IDLE) ? '0 : idx_r + IDX_W'(1);
  assign scan_hit  = (rd_ip == query_r);
  assign scan_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  arpc_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (count_r[IDX_W-1:0]),
    .wr_ip    (in_sender_ip),
    .wr_mac   (in_sender_mac),
    .rd_addr  (rd_addr),
    .rd_ip_r  (rd_ip),
    .rd_mac_r (rd_mac)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      own_ip_r    <= OWN_IP_RST;
      own_mac_r   <= OWN_MAC_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_OWN_IP:  own_ip_r  <= cfg_data[31:0];
          CFG_OWN_MAC: own_mac_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_req_type == REQ_LEARN) begin
              res_send_r  <= reply_due;
              res_rmac_r  <= reply_due ? in_sender_mac : '0;
              res_rip_r   <= reply_due ? in_sender_ip : '0;
              res_hit_r   <= 1'b0;
              res_lmac_r  <= '0;
              res_count_r <= wr_en ? count_r + CNT_W'(1) : count_r;
              if (wr_en) begin
                count_r <= count_r + CNT_W'(1);
              end
              state_r <= ST_FINISH;
            end else begin
              query_r     <= in_query_ip;
              res_send_r  <= 1'b0;
              res_rmac_r  <= '0;
              res_rip_r   <= '0;
              res_hit_r   <= 1'b0;
              res_lmac_r  <= '0;
              res_count_r <= count_r;
              idx_r       <= '0;
              state_r     <= (count_r == '0) ? ST_FINISH : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            res_hit_r  <= 1'b1;
            res_lmac_r <= rd_mac;
            state_r    <= ST_FINISH;
          end else if (scan_last) begin
            state_r <= ST_FINISH;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_send_r  <= res_send_r;
            out_rmac_r  <= res_rmac_r;
            out_rip_r   <= res_rip_r;
            out_hit_r   <= res_hit_r;
            out_lmac_r  <= res_lmac_r;
            out_count_r <= res_count_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_count_ext   = {5'b0, out_count_r};
  assign out_valid       = out_valid_r;
  assign out_send_reply  = out_send_r;
  assign out_reply_mac   = out_rmac_r;
  assign out_reply_ip    = out_rip_r;
  assign out_lookup_hit  = out_hit_r;
  assign out_lookup_mac  = out_lmac_r;
  assign out_entry_count = out_count_ext[4:0];

endmodule

@@ rtl/arp_cache_and_responder_checker.sv @@
// Port-level checker for the ARP cache, bound to the top level.
`include "arp_cache_and_responder_defines.svh"

module arp_cache_and_responder_checker import arpc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_send_reply,
  input logic [47:0] out_reply_mac,
  input logic [31:0] out_reply_ip,
  input logic        out_lookup_hit,
  input logic [47:0] out_lookup_mac
);

  `ARPC_ASSERT_NEXT(busy_after_accept, in_valid && !in_stall, in_stall)
  `ARPC_ASSERT_SAME(hit_excludes_reply, out_valid && out_lookup_hit, !out_send_reply)
  `ARPC_ASSERT_SAME(miss_mac_zero, out_valid && !out_lookup_hit, out_lookup_mac == 48'h0)
  `ARPC_ASSERT_SAME(no_reply_zero, out_valid && !out_send_reply,
                    out_reply_mac == 48'h0 && out_reply_ip == 32'h0)
  `ARPC_ASSERT_NEXT(out_hold, out_valid && out_stall,
                    out_valid && $stable(out_lookup_mac) && $stable(out_reply_ip))

endmodule

bind arp_cache_and_responder arp_cache_and_responder_checker u_checker (.*);
